// File: rtl/core/kaf_pkg.sv
// Shared constants, command codes and helpers for the two-axis angle filter.
package kaf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int STEP_FRAC   = 16;
    localparam int DATA_W      = 32;
    localparam int STEP_W      = 16;
    localparam int CFG_W       = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int ITEM_W      = 4 * DATA_W;

    // gain runs from 0 to 1.0, one bit more than the fraction
    localparam int GAIN_W    = FRAC_BITS + 1;
    localparam int MA_W      = DATA_W + 2;
    localparam int MB_W      = GAIN_W + 1;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int SAT_W     = PROD_W + 2;
    localparam int DEN_W     = DATA_W + 1;
    localparam int REM_W     = DEN_W + 1;
    localparam int DIV_CNT_W = $clog2(GAIN_W);

    localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROC_NOISE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MEAS_VAR    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_UNCERT = 3'd3;

    localparam logic [STEP_W-1:0] STEP_TIME_RESET   = 16'd262;
    localparam logic [CFG_W-1:0]  PROC_NOISE_RESET  = 24'd17;
    localparam logic [CFG_W-1:0]  MEAS_VAR_RESET    = 24'd589824;
    localparam logic [CFG_W-1:0]  INIT_UNCERT_RESET = 24'd262144;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE  = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL_RATE = 4'd2;
    localparam logic [OP_W-1:0] OP_PRED     = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV      = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_CORR = 4'd5;
    localparam logic [OP_W-1:0] OP_EST      = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL_UNC  = 4'd7;
    localparam logic [OP_W-1:0] OP_UNC      = 4'd8;
    localparam logic [OP_W-1:0] OP_LOAD_OUT = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            axis;
    } kaf_cmd_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] max_v;
        logic signed [SAT_W-1:0] min_v;
        max_v = SAT_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
        min_v = SAT_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}));
        if (v > max_v)
            sat32 = max_v[DATA_W-1:0];
        else if (v < min_v)
            sat32 = min_v[DATA_W-1:0];
        else
            sat32 = v[DATA_W-1:0];
    endfunction

endpackage

// File: rtl/core/kalman_angle_filter_2axis_top.sv
// Two-axis scalar Kalman angle filter, top level.
//
// Each input item carries roll and pitch gyro rates and accelerometer angles (signed
// Q15.16); each yields one result with both filtered angles (saturated) and both updated
// uncertainties (unsigned Q16.16). The two axes run one after the other through one
// shared multiplier, and the gain of each axis comes from a restoring divider that
// produces one of its 17 bits per cycle. A new item is accepted once the previous one
// has left the datapath; a result waiting on the output does not block it.
// Configuration writes take effect at once; writing initial_uncertainty also reloads
// both uncertainties.
module kalman_angle_filter_2axis_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [kaf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [kaf_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // roll_rate, roll_measured, pitch_rate, pitch_measured
    input  logic [kaf_pkg::ITEM_W-1:0]           s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // roll_estimate, pitch_estimate, roll_variance, pitch_variance
    output logic [kaf_pkg::ITEM_W-1:0]           m_tdata
);

    kaf_pkg::kaf_cmd_t cmd;

    kaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    kaf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/core/kaf_ctrl.sv
// Sequencer for the filter: steps both axes through the shared datapath.
module kaf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output kaf_pkg::kaf_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL_RATE = 4'd1;
    localparam logic [3:0] ST_PRED     = 4'd2;
    localparam logic [3:0] ST_DIV      = 4'd3;
    localparam logic [3:0] ST_MUL_CORR = 4'd4;
    localparam logic [3:0] ST_EST      = 4'd5;
    localparam logic [3:0] ST_MUL_UNC  = 4'd6;
    localparam logic [3:0] ST_UNC      = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0]                      state_reg, state_next;
    logic                            axis_reg, axis_next;
    logic [kaf_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;
        cmd.op         = kaf_pkg::OP_NONE;
        cmd.axis       = axis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = kaf_pkg::OP_CAPTURE;
                    axis_next  = 1'b0;
                    state_next = ST_MUL_RATE;
                end
            end
            ST_MUL_RATE:
            begin
                cmd.op     = kaf_pkg::OP_MUL_RATE;
                state_next = ST_PRED;
            end
            ST_PRED:
            begin
                cmd.op     = kaf_pkg::OP_PRED;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op   = kaf_pkg::OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == kaf_pkg::DIV_CNT_W'(kaf_pkg::GAIN_W - 1))
                    state_next = ST_MUL_CORR;
            end
            ST_MUL_CORR:
            begin
                cmd.op     = kaf_pkg::OP_MUL_CORR;
                state_next = ST_EST;
            end
            ST_EST:
            begin
                cmd.op     = kaf_pkg::OP_EST;
                state_next = ST_MUL_UNC;
            end
            ST_MUL_UNC:
            begin
                cmd.op     = kaf_pkg::OP_MUL_UNC;
                state_next = ST_UNC;
            end
            ST_UNC:
            begin
                cmd.op = kaf_pkg::OP_UNC;
                if (axis_reg)
                    state_next = ST_DONE;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_MUL_RATE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.op         = kaf_pkg::OP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// File: rtl/core/kaf_datapath.sv
// Filter datapath: configuration, axis state, shared multiplier and gain divider.
module kaf_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  kaf_pkg::kaf_cmd_t                    cmd,
    input  logic                                 cfg_we,
    input  logic [kaf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [kaf_pkg::CFG_W-1:0]            cfg_data,
    input  logic [kaf_pkg::ITEM_W-1:0]           s_tdata,
    output logic [kaf_pkg::ITEM_W-1:0]           m_tdata
);

    localparam int DW = kaf_pkg::DATA_W;
    localparam int F  = kaf_pkg::FRAC_BITS;

    logic [kaf_pkg::STEP_W-1:0] step_time_reg;
    logic [kaf_pkg::CFG_W-1:0]  proc_noise_reg;
    logic [kaf_pkg::CFG_W-1:0]  meas_var_reg;

    logic signed [DW-1:0] est_reg [2];
    logic [DW-1:0]        unc_reg [2];

    logic signed [DW-1:0] rate_in_reg [2];
    logic signed [DW-1:0] meas_in_reg [2];

    logic signed [DW-1:0]                  pred_reg;
    logic [DW-1:0]                         p_reg;
    logic [kaf_pkg::DEN_W-1:0]             den_reg;
    logic [kaf_pkg::REM_W-1:0]             rem_reg;
    logic [kaf_pkg::GAIN_W-1:0]            q_reg;
    logic signed [kaf_pkg::PROD_W-1:0]     prod_reg;
    logic [kaf_pkg::ITEM_W-1:0]            out_reg;

    logic signed [DW-1:0]              rate_sel, meas_sel, est_sel;
    logic [DW-1:0]                     unc_sel;
    logic signed [DW:0]                diff;
    logic [kaf_pkg::GAIN_W-1:0]        gain, one_minus_gain;
    logic signed [kaf_pkg::MA_W-1:0]   mul_a;
    logic signed [kaf_pkg::MB_W-1:0]   mul_b;
    logic signed [kaf_pkg::PROD_W-1:0] prod_next;
    logic signed [kaf_pkg::PROD_W:0]   rnd_step, rnd_frac;
    logic signed [kaf_pkg::SAT_W-1:0]  pred_sum, est_sum;
    logic [DW:0]                       p_sum;
    logic [DW-1:0]                     p_next;
    logic [kaf_pkg::DEN_W-1:0]         den_next;
    logic                              ge;
    logic [kaf_pkg::REM_W-1:0]         rem_sub;

    always_comb
    begin
        rate_sel = rate_in_reg[cmd.axis];
        meas_sel = meas_in_reg[cmd.axis];
        est_sel  = est_reg[cmd.axis];
        unc_sel  = unc_reg[cmd.axis];

        diff           = (DW + 1)'(meas_sel) - (DW + 1)'(pred_reg);
        gain           = (den_reg == '0) ? '0 : q_reg;
        one_minus_gain = kaf_pkg::GAIN_W'(1 << F) - gain;

        unique case (cmd.op)
            kaf_pkg::OP_MUL_RATE:
            begin
                mul_a = kaf_pkg::MA_W'(rate_sel);
                mul_b = kaf_pkg::MB_W'(signed'({1'b0, step_time_reg}));
            end
            kaf_pkg::OP_MUL_CORR:
            begin
                mul_a = kaf_pkg::MA_W'(diff);
                mul_b = signed'({1'b0, gain});
            end
            kaf_pkg::OP_MUL_UNC:
            begin
                mul_a = signed'({2'b00, p_reg});
                mul_b = signed'({1'b0, one_minus_gain});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;

        rnd_step = ((kaf_pkg::PROD_W + 1)'(prod_reg)
                    + (kaf_pkg::PROD_W + 1)'(1 << (kaf_pkg::STEP_FRAC - 1))) >>> kaf_pkg::STEP_FRAC;
        rnd_frac = ((kaf_pkg::PROD_W + 1)'(prod_reg)
                    + (kaf_pkg::PROD_W + 1)'(1 << (F - 1))) >>> F;
        pred_sum = kaf_pkg::SAT_W'(est_sel) + kaf_pkg::SAT_W'(rnd_step);
        est_sum  = kaf_pkg::SAT_W'(pred_reg) + kaf_pkg::SAT_W'(rnd_frac);

        // saturate the grown uncertainty at all ones
        p_sum    = {1'b0, unc_sel} + (DW + 1)'(proc_noise_reg);
        p_next   = p_sum[DW] ? '1 : p_sum[DW-1:0];
        den_next = {1'b0, p_reg} + kaf_pkg::DEN_W'(meas_var_reg);

        ge      = (rem_reg >= {1'b0, den_reg});
        rem_sub = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg  <= kaf_pkg::STEP_TIME_RESET;
            proc_noise_reg <= kaf_pkg::PROC_NOISE_RESET;
            meas_var_reg   <= kaf_pkg::MEAS_VAR_RESET;
            est_reg[0]     <= '0;
            est_reg[1]     <= '0;
            unc_reg[0]     <= DW'(kaf_pkg::INIT_UNCERT_RESET);
            unc_reg[1]     <= DW'(kaf_pkg::INIT_UNCERT_RESET);
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    kaf_pkg::REG_STEP_TIME:   step_time_reg  <= cfg_data[kaf_pkg::STEP_W-1:0];
                    kaf_pkg::REG_PROC_NOISE:  proc_noise_reg <= cfg_data;
                    kaf_pkg::REG_MEAS_VAR:    meas_var_reg   <= cfg_data;
                    kaf_pkg::REG_INIT_UNCERT:
                    begin
                        unc_reg[0] <= DW'(cfg_data);
                        unc_reg[1] <= DW'(cfg_data);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == kaf_pkg::OP_EST)
                est_reg[cmd.axis] <= kaf_pkg::sat32(est_sum);
            if (cmd.op == kaf_pkg::OP_UNC)
                unc_reg[cmd.axis] <= rnd_frac[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == kaf_pkg::OP_MUL_RATE || cmd.op == kaf_pkg::OP_MUL_CORR
            || cmd.op == kaf_pkg::OP_MUL_UNC)
            prod_reg <= prod_next;
        unique case (cmd.op)
            kaf_pkg::OP_CAPTURE:
            begin
                rate_in_reg[0] <= s_tdata[DW-1:0];
                meas_in_reg[0] <= s_tdata[2*DW-1:DW];
                rate_in_reg[1] <= s_tdata[3*DW-1:2*DW];
                meas_in_reg[1] <= s_tdata[4*DW-1:3*DW];
            end
            kaf_pkg::OP_MUL_RATE:
            begin
                p_reg <= p_next;
            end
            kaf_pkg::OP_PRED:
            begin
                pred_reg <= kaf_pkg::sat32(pred_sum);
                den_reg  <= den_next;
                rem_reg  <= kaf_pkg::REM_W'(p_reg);
                q_reg    <= '0;
            end
            kaf_pkg::OP_DIV:
            begin
                // one gain bit per step, restoring
                q_reg   <= {q_reg[kaf_pkg::GAIN_W-2:0], ge};
                rem_reg <= {rem_sub[kaf_pkg::REM_W-2:0], 1'b0};
            end
            kaf_pkg::OP_LOAD_OUT:
            begin
                out_reg <= {unc_reg[1], unc_reg[0], est_reg[1], est_reg[0]};
            end
            default:
            begin
            end
        endcase
    end

    assign m_tdata = out_reg;

endmodule
